FILE: sv/pngad_pkg.sv
// Shared types and constants for the PNG chunk walker with animation detection.
// Used by pngad_walker and png_chunk_animation_detector; depends on nothing else.
package pngad_pkg;

    localparam int DataW     = 8;
    localparam int VerdictW  = 2;
    localparam int PhaseW    = 3;
    localparam int IndexW    = 3;
    localparam int WordW     = 32;
    localparam int SkipW     = 33;

    // Walker phases.
    localparam logic [PhaseW-1:0] PH_SIG  = 3'd0;
    localparam logic [PhaseW-1:0] PH_LEN  = 3'd1;
    localparam logic [PhaseW-1:0] PH_TYPE = 3'd2;
    localparam logic [PhaseW-1:0] PH_SKIP = 3'd3;
    localparam logic [PhaseW-1:0] PH_DONE = 3'd4;

    // Verdict codes.
    localparam logic [VerdictW-1:0] VERDICT_NONE     = 2'd0;
    localparam logic [VerdictW-1:0] VERDICT_ANIMATED = 2'd1;
    localparam logic [VerdictW-1:0] VERDICT_STILL    = 2'd2;

    // Chunk type codes, first byte in the top octet.
    localparam logic [WordW-1:0] TYPE_ACTL = 32'h6163_544C;
    localparam logic [WordW-1:0] TYPE_IDAT = 32'h4944_4154;

    localparam logic [IndexW-1:0] FIELD_BYTES = 3'd4;
    localparam logic [SkipW-1:0]  CRC_BYTES   = 33'd4;

    typedef struct packed {
        logic [DataW-1:0] data_byte;
        logic             file_start;
    } pngad_item_t;

endpackage

FILE: sv/pngad_walker.sv
// Chunk walker state and its next-state logic for one byte per cycle in which step is high.
// Depends on pngad_pkg for phase codes, chunk type codes and the item type.
module pngad_walker
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   step,
    input  pngad_pkg::pngad_item_t                 item,
    output logic [pngad_pkg::VerdictW-1:0]         verdict_next
);
    import pngad_pkg::*;

    logic [PhaseW-1:0]   phase_reg,  phase_next;
    logic [IndexW-1:0]   index_reg,  index_next;
    logic [WordW-1:0]    length_reg, length_next;
    logic [WordW-1:0]    type_reg,   type_next;
    logic [SkipW-1:0]    skip_reg,   skip_next;
    logic [VerdictW-1:0] held_reg;

    logic [PhaseW-1:0]   cur_phase;
    logic [IndexW-1:0]   cur_index;
    logic [VerdictW-1:0] cur_verdict;
    logic [IndexW-1:0]   index_inc;
    logic [WordW-1:0]    type_shifted;
    logic [SkipW-1:0]    skip_dec;

    // A file start byte sees the reset state. Length and type are fully
    // rewritten before they are used, so only these three need the override.
    assign cur_phase    = item.file_start ? PH_SIG : phase_reg;
    assign cur_index    = item.file_start ? '0 : index_reg;
    assign cur_verdict  = item.file_start ? VERDICT_NONE : held_reg;
    assign index_inc    = cur_index + 1'b1;
    assign type_shifted = {type_reg[WordW-DataW-1:0], item.data_byte};
    assign skip_dec     = (skip_reg != '0) ? skip_reg - 1'b1 : skip_reg;

    always_comb
    begin
        phase_next   = cur_phase;
        index_next   = cur_index;
        length_next  = length_reg;
        type_next    = type_reg;
        skip_next    = skip_reg;
        verdict_next = cur_verdict;
        unique case (cur_phase)
            PH_SIG:
            begin
                index_next = index_inc;
                if (index_inc == '0)
                begin
                    phase_next  = PH_LEN;
                    length_next = '0;
                end
            end
            PH_LEN:
            begin
                length_next = {length_reg[WordW-DataW-1:0], item.data_byte};
                index_next  = index_inc;
                if (index_inc >= FIELD_BYTES)
                begin
                    index_next = '0;
                    type_next  = '0;
                    phase_next = PH_TYPE;
                end
            end
            PH_TYPE:
            begin
                type_next  = type_shifted;
                index_next = index_inc;
                if (index_inc >= FIELD_BYTES)
                begin
                    index_next = '0;
                    if (type_shifted == TYPE_ACTL)
                    begin
                        verdict_next = VERDICT_ANIMATED;
                        phase_next   = PH_DONE;
                    end
                    else if (type_shifted == TYPE_IDAT)
                    begin
                        verdict_next = VERDICT_STILL;
                        phase_next   = PH_DONE;
                    end
                    else
                    begin
                        skip_next  = {1'b0, length_reg} + CRC_BYTES;
                        phase_next = PH_SKIP;
                    end
                end
            end
            PH_SKIP:
            begin
                skip_next = skip_dec;
                if (skip_dec == '0)
                begin
                    length_next = '0;
                    index_next  = '0;
                    phase_next  = PH_LEN;
                end
            end
            default:
            begin
                phase_next = PH_DONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_SIG;
            index_reg  <= '0;
            length_reg <= '0;
            type_reg   <= '0;
            skip_reg   <= '0;
            held_reg   <= VERDICT_NONE;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            index_reg  <= index_next;
            length_reg <= length_next;
            type_reg   <= type_next;
            skip_reg   <= skip_next;
            held_reg   <= verdict_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_done_iff_decided: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DONE) == (held_reg != VERDICT_NONE))
        else $error("walker phase and held verdict disagree");

    a_skip_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_SKIP) |-> (skip_reg != '0))
        else $error("skip phase with nothing left to skip");

    a_field_index: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_LEN || phase_reg == PH_TYPE) |-> (index_reg < FIELD_BYTES))
        else $error("byte index beyond a four-byte field");

    a_verdict_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (step && !item.file_start && held_reg != VERDICT_NONE) |=> $stable(held_reg))
        else $error("verdict changed without a file start");
`endif

endmodule

FILE: sv/png_chunk_animation_detector.sv
// Top level of the PNG chunk walker: input register, walker, output register.
// Depends on pngad_pkg and pngad_walker.
//
// Usage: the block takes one PNG file byte per input transfer on data_byte,
// with file_start high on the first byte of each file, which restarts the
// walk. Each input transfer gives exactly one output transfer carrying
// verdict: 0 while undecided, 1 once an acTL chunk type has been seen, 2 once
// IDAT has been seen first. The verdict is reported on the last type byte of
// the deciding chunk and then holds until the next file start.
// Both channels use valid and stall; a transfer takes place on a clock edge
// with valid high and stall low.
// A byte taken is held in the input register, walked from there, and its verdict
// is offered from the output register. Throughput is one byte per cycle while the
// receiver does not stall, set by the walker update between the input and
// output registers. When the receiver stalls, the output register holds its
// verdict and one further byte waits in the input register; in_stall rises
// only once both are full. Reset empties both registers and puts the walker
// in the signature phase, as if a file began at reset.
module png_chunk_animation_detector
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [pngad_pkg::DataW-1:0]     data_byte,
    input  logic                            file_start,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [pngad_pkg::VerdictW-1:0]  verdict
);
    import pngad_pkg::*;

    logic                in_valid_reg;
    pngad_item_t         item_reg;
    logic                out_valid_reg;
    logic [VerdictW-1:0] verdict_reg;
    logic [VerdictW-1:0] verdict_next;
    logic                advance;
    logic                in_take;
    logic                step;

    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;
    assign step     = in_valid_reg && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance || !in_valid_reg)
            begin
                in_valid_reg <= in_take;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.data_byte  <= data_byte;
            item_reg.file_start <= file_start;
        end
        if (step)
        begin
            verdict_reg <= verdict_next;
        end
    end

    pngad_walker u_walker
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .item         (item_reg),
        .verdict_next (verdict_next)
    );

    assign out_valid = out_valid_reg;
    assign verdict   = verdict_reg;

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for png_chunk_animation_detector: directed PNG streams, then
// random files, chunks and noise under varying idle and stall patterns.
// Depends on pngad_pkg and the detector RTL only.
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import pngad_pkg::*;

    localparam int StallLimit = 2000;
    localparam int HoldCycles = 60;
    localparam int PhaseItems = 310;
    localparam int DirRows    = 34;

    typedef struct packed {
        logic [DataW-1:0]    data;
        logic                start;
        logic                typed;
        logic [VerdictW-1:0] want;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [DataW-1:0] data_byte = '0;
    logic file_start = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [VerdictW-1:0] verdict;

    // Walker state mirrored in the testbench.
    logic [PhaseW-1:0]   walk_phase;
    logic [IndexW-1:0]   field_pos;
    logic [WordW-1:0]    length_acc;
    logic [WordW-1:0]    type_acc;
    logic [SkipW-1:0]    skip_left;
    logic [VerdictW-1:0] decided;

    logic [VerdictW-1:0] verdict_q[$];
    logic [VerdictW-1:0] oldest_verdict;
    int errors = 0;
    int items_sent = 0;
    int quiet_cycles = 0;
    int idle_pct = 0;
    int stall_pct = 0;
    int hold_left = 0;
    logic hold_req = 1'b0;

    // The first file has no file_start, so it is walked from reset; it carries a
    // huge length and a near miss on acTL, and the second file interrupts its skip.
    dir_row_t dir_rows [DirRows] = '{
        '{8'h00, 1'b0, 1'b1, VERDICT_NONE}, '{8'hFF, 1'b0, 1'b1, VERDICT_NONE},
        '{8'h00, 1'b0, 1'b1, VERDICT_NONE}, '{8'hFF, 1'b0, 1'b1, VERDICT_NONE},
        '{8'h00, 1'b0, 1'b1, VERDICT_NONE}, '{8'hFF, 1'b0, 1'b1, VERDICT_NONE},
        '{8'h00, 1'b0, 1'b1, VERDICT_NONE}, '{8'hFF, 1'b0, 1'b1, VERDICT_NONE},
        '{8'hFF, 1'b0, 1'b1, VERDICT_NONE}, '{8'hFF, 1'b0, 1'b1, VERDICT_NONE},
        '{8'hFF, 1'b0, 1'b1, VERDICT_NONE}, '{8'hFF, 1'b0, 1'b1, VERDICT_NONE},
        '{8'h61, 1'b0, 1'b1, VERDICT_NONE}, '{8'h63, 1'b0, 1'b1, VERDICT_NONE},
        '{8'h54, 1'b0, 1'b1, VERDICT_NONE}, '{8'h4D, 1'b0, 1'b1, VERDICT_NONE},
        '{8'h00, 1'b0, 1'b1, VERDICT_NONE},
        '{8'h89, 1'b1, 1'b1, VERDICT_NONE}, '{8'h50, 1'b0, 1'b0, VERDICT_NONE},
        '{8'h4E, 1'b0, 1'b0, VERDICT_NONE}, '{8'h47, 1'b0, 1'b0, VERDICT_NONE},
        '{8'h0D, 1'b0, 1'b0, VERDICT_NONE}, '{8'h0A, 1'b0, 1'b0, VERDICT_NONE},
        '{8'h1A, 1'b0, 1'b0, VERDICT_NONE}, '{8'h0A, 1'b0, 1'b0, VERDICT_NONE},
        '{8'h00, 1'b0, 1'b0, VERDICT_NONE}, '{8'h00, 1'b0, 1'b0, VERDICT_NONE},
        '{8'h00, 1'b0, 1'b0, VERDICT_NONE}, '{8'h00, 1'b0, 1'b0, VERDICT_NONE},
        '{8'h61, 1'b0, 1'b0, VERDICT_NONE}, '{8'h63, 1'b0, 1'b0, VERDICT_NONE},
        '{8'h54, 1'b0, 1'b0, VERDICT_NONE}, '{8'h4C, 1'b0, 1'b1, VERDICT_ANIMATED},
        '{8'hFF, 1'b0, 1'b1, VERDICT_ANIMATED}
    };

    png_chunk_animation_detector u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_byte  (data_byte),
        .file_start (file_start),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .verdict    (verdict)
    );

    always #6ns clk = ~clk;

    task automatic clear_walk();
        walk_phase = PH_SIG;
        field_pos  = '0;
        length_acc = '0;
        type_acc   = '0;
        skip_left  = '0;
        decided    = VERDICT_NONE;
    endtask

    // Advances the mirrored walker by one byte and returns the verdict it reports.
    task automatic walk_byte(input logic [DataW-1:0] b, input logic s,
                             output logic [VerdictW-1:0] v);
        if (s)
            clear_walk();
        case (walk_phase)
            PH_SIG:
            begin
                field_pos = field_pos + 1'b1;
                if (field_pos == '0)
                begin
                    walk_phase = PH_LEN;
                    length_acc = '0;
                end
            end
            PH_LEN:
            begin
                length_acc = {length_acc[WordW-DataW-1:0], b};
                field_pos  = field_pos + 1'b1;
                if (field_pos >= FIELD_BYTES)
                begin
                    field_pos  = '0;
                    type_acc   = '0;
                    walk_phase = PH_TYPE;
                end
            end
            PH_TYPE:
            begin
                type_acc  = {type_acc[WordW-DataW-1:0], b};
                field_pos = field_pos + 1'b1;
                if (field_pos >= FIELD_BYTES)
                begin
                    field_pos = '0;
                    if (type_acc == TYPE_ACTL)
                    begin
                        decided    = VERDICT_ANIMATED;
                        walk_phase = PH_DONE;
                    end
                    else if (type_acc == TYPE_IDAT)
                    begin
                        decided    = VERDICT_STILL;
                        walk_phase = PH_DONE;
                    end
                    else
                    begin
                        skip_left  = {1'b0, length_acc} + CRC_BYTES;
                        walk_phase = PH_SKIP;
                    end
                end
            end
            PH_SKIP:
            begin
                if (skip_left != '0)
                    skip_left = skip_left - 1'b1;
                if (skip_left == '0)
                begin
                    length_acc = '0;
                    field_pos  = '0;
                    walk_phase = PH_LEN;
                end
            end
            default:
                walk_phase = PH_DONE;
        endcase
        v = decided;
    endtask

    // Offers one byte, holds it until the transfer and records the verdict it should give.
    task automatic offer_byte(input logic [DataW-1:0] b, input logic s, input logic typed,
                              input logic [VerdictW-1:0] typed_v);
        logic [VerdictW-1:0] v;
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        data_byte  <= b;
        file_start <= s;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        walk_byte(b, s, v);
        verdict_q.push_back(typed ? typed_v : v);
        items_sent++;
    endtask

    task automatic send_word(input logic [WordW-1:0] w);
        for (int k = 3; k >= 0; k--)
            offer_byte(w[8*k +: 8], 1'b0, 1'b0, VERDICT_NONE);
    endtask

    // One file: signature, some ancillary chunks, then mostly a deciding chunk.
    // Huge lengths and truncated files are abandoned part way, as a new file follows.
    task automatic send_png_file();
        int chunks;
        int pick;
        int body;
        logic [WordW-1:0] len_word;
        logic [WordW-1:0] type_word;
        logic huge;
        chunks = $urandom_range(3);
        for (int i = 0; i < 8; i++)
            offer_byte(8'($urandom_range(255)), i == 0, 1'b0, VERDICT_NONE);
        for (int c = 0; c <= chunks; c++)
        begin
            pick = $urandom_range(99);
            if (pick < 80)
                len_word = $urandom_range(6);
            else if (pick < 92)
                len_word = $urandom_range(40, 7);
            else
                len_word = $urandom() | 32'h8000_0000;
            huge = len_word[WordW-1];
            if (c == chunks && $urandom_range(9) != 0)
            begin
                type_word = $urandom_range(1) ? TYPE_ACTL : TYPE_IDAT;
                send_word(len_word);
                send_word(type_word);
                for (int t = $urandom_range(3); t > 0; t--)
                    offer_byte(8'($urandom_range(255)), 1'b0, 1'b0, VERDICT_NONE);
                return;
            end
            if ($urandom_range(1))
                type_word = $urandom();
            else
                type_word = ($urandom_range(1) ? TYPE_ACTL : TYPE_IDAT)
                            ^ (32'h1 << (8 * $urandom_range(3) + $urandom_range(7)));
            send_word(len_word);
            send_word(type_word);
            if (huge)
                body = $urandom_range(12, 1);
            else if (c == chunks)
                body = $urandom_range(int'(len_word) + 3);
            else
                body = int'(len_word) + 4;
            for (int d = 0; d < body; d++)
                offer_byte(8'($urandom_range(255)), 1'b0, 1'b0, VERDICT_NONE);
            if (huge)
                return;
        end
    endtask

    // Stimulus.
    initial
    begin
        clear_walk();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int r = 0; r < DirRows; r++)
            offer_byte(dir_rows[r].data, dir_rows[r].start, dir_rows[r].typed,
                       dir_rows[r].want);
        for (int ph = 0; ph < 4; ph++)
        begin
            // Let the block drain completely between idling patterns.
            in_valid <= 1'b0;
            while (verdict_q.size() != 0)
                @(posedge clk);
            idle_pct  = (ph == 1) ? 48 : (ph == 3) ? 24 : 0;
            stall_pct = (ph == 2) ? 48 : (ph == 3) ? 24 : 0;
            if (ph == 0)
                hold_req = 1'b1;
            while (items_sent < DirRows + (ph + 1) * PhaseItems)
            begin
                if ($urandom_range(9) == 0)
                begin
                    for (int n = $urandom_range(16, 1); n > 0; n--)
                        offer_byte(8'($urandom_range(255)), $urandom_range(7) == 0,
                                   1'b0, VERDICT_NONE);
                end
                else
                    send_png_file();
            end
        end
        in_valid <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Receiver: random stalls, plus one long hold-off counted here.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HoldCycles;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Every output transfer is compared with the oldest outstanding verdict.
    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
        begin
            if (verdict_q.size() == 0)
            begin
                $display("%0t: verdict %0d transferred with none outstanding", $time, verdict);
                errors++;
            end
            else
            begin
                oldest_verdict = verdict_q.pop_front();
                if (verdict !== oldest_verdict)
                begin
                    $display("%0t: verdict expected %0d, got %0d", $time, oldest_verdict,
                             verdict);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles without any transfer on either channel.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= StallLimit)
        begin
            $display("%0t: no transfer for %0d cycles", $time, StallLimit);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

endmodule

FILE: png_chunk_animation_detector.f
sv/pngad_pkg.sv
sv/pngad_walker.sv
sv/png_chunk_animation_detector.sv
sim/testbench.sv
